// ===== rtl/tt_pkg.sv =====
`default_nettype none

package tt_pkg;

    localparam int DEF_TABLE_ENTRIES = 65536;
    localparam int DEF_MATE_MARGIN   = 1000;
    localparam int DEF_SCORE_BITS    = 16;
    localparam int DEF_MOVE_BITS     = 16;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic        [CFG_W-1:0] RST_INDEX_MASK = 16'hFFFF;
    localparam logic signed [CFG_W-1:0] RST_SCORE_MIN  = -16'sd32000;
    localparam logic signed [CFG_W-1:0] RST_SCORE_MAX  = 16'sd32000;

    // Score kinds with a meaning of their own; all others pass through.
    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_PV   = 3'd1;

    typedef enum logic [1:0] {
        REQ_STORE    = 2'd0,
        REQ_SET_MOVE = 2'd1,
        REQ_LOOKUP   = 2'd2,
        REQ_CLEAR    = 2'd3
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INDEX_MASK = 2'd0,
        CFG_SCORE_MIN  = 2'd1,
        CFG_SCORE_MAX  = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_WIPE,
        ST_IDLE,
        ST_SLOT,
        ST_CLEAR,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic exec;
        logic wipe;
    } t_tbl_ctrl;

endpackage

`default_nettype wire

// ===== rtl/transposition_table.sv =====
// Direct-mapped table of search results.
// Requests arrive on the input channel (i_in_valid / o_in_stall); each one
// gives exactly one result on the output channel (o_out_valid /
// i_out_stall). A transfer happens at a rising edge with valid high and
// stall low. Configuration is written through i_cfg_wr_en, i_cfg_index and
// i_cfg_data, which the user must do only while no request is in flight;
// the block does not enforce this. For store, set-move and lookup, the
// transfer cycle registers the masked key, the next cycle folds it into a
// slot and reads the table, and the third updates the entry and registers
// the result. A clear instead empties min(index_mask, TABLE_ENTRIES-1) + 1
// slots, one per cycle, after the slot step and before it registers its
// result. A new request is taken only once the last one has registered
// its result.
// After reset the block empties all TABLE_ENTRIES slots, one per cycle,
// and holds o_in_stall high meanwhile; configuration writes still land.
// The result register holds its value while i_out_stall is high. The next
// request is still taken in that time, and it then waits in its last step
// until the result register is free.
`default_nettype none

module transposition_table #(
    parameter int  TABLE_ENTRIES = tt_pkg::DEF_TABLE_ENTRIES,
    parameter int  MATE_MARGIN   = tt_pkg::DEF_MATE_MARGIN,
    parameter int  SCORE_BITS    = tt_pkg::DEF_SCORE_BITS,
    parameter int  MOVE_BITS     = tt_pkg::DEF_MOVE_BITS,
    localparam int ADDR_W        = $clog2(TABLE_ENTRIES)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [tt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [tt_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [1:0]                   i_req_type,
    input  wire logic [63:0]                  i_hash_key,
    input  wire logic signed [15:0]           i_score_in,
    input  wire logic [2:0]                   i_kind_in,
    input  wire logic [7:0]                   i_search_depth,
    input  wire logic [7:0]                   i_ply_in,
    input  wire logic [15:0]                  i_move_in,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [2:0]                        o_kind_out,
    output logic signed [15:0]                o_score_out,
    output logic                              o_move_found,
    output logic [15:0]                       o_move_out
);

    localparam logic [31:0] LAST32 = 32'(TABLE_ENTRIES - 1);

    tt_pkg::t_state     r_state;
    tt_pkg::t_state     n_state;
    logic [ADDR_W-1:0]  r_clr;
    logic [ADDR_W-1:0]  n_clr;
    logic [ADDR_W-1:0]  r_clr_last;
    logic [ADDR_W-1:0]  n_clr_last;
    logic [ADDR_W-1:0]  clr_last_cfg;
    tt_pkg::t_tbl_ctrl  ctrl;

    logic [15:0]        r_cfg_mask;
    logic signed [15:0] r_cfg_min;
    logic signed [15:0] r_cfg_max;

    tt_pkg::t_req       r_req;
    logic [63:0]        r_key;
    logic signed [15:0] r_score;
    logic [2:0]         r_kind;
    logic [7:0]         r_depth;
    logic [7:0]         r_ply;
    logic [15:0]        r_move;

    logic               r_out_valid;
    logic [2:0]         r_kind_out;
    logic [15:0]        r_score_out;
    logic               r_move_found;
    logic [15:0]        r_move_out;

    logic               accept;
    logic               out_free;
    logic [ADDR_W-1:0]  slot;
    logic [2:0]         res_kind;
    logic [15:0]        res_score;
    logic               res_found;
    logic [15:0]        res_move;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // A clear stops at the table end when the mask reaches past it.
    assign clr_last_cfg = (32'(r_cfg_mask) > LAST32) ? ADDR_W'(LAST32) : ADDR_W'(r_cfg_mask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mask <= tt_pkg::RST_INDEX_MASK;
            r_cfg_min  <= tt_pkg::RST_SCORE_MIN;
            r_cfg_max  <= tt_pkg::RST_SCORE_MAX;
        end else if (i_cfg_wr_en) begin
            unique case (tt_pkg::t_cfg_idx'(i_cfg_index))
                tt_pkg::CFG_INDEX_MASK: r_cfg_mask <= i_cfg_data;
                tt_pkg::CFG_SCORE_MIN:  r_cfg_min  <= $signed(i_cfg_data);
                tt_pkg::CFG_SCORE_MAX:  r_cfg_max  <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tt_pkg::ST_WIPE;
            r_clr      <= '0;
            r_clr_last <= ADDR_W'(LAST32);
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_clr_last <= n_clr_last;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_clr_last = r_clr_last;
        ctrl       = '0;
        o_in_stall = (r_state != tt_pkg::ST_IDLE);
        unique case (r_state)
            tt_pkg::ST_WIPE: begin
                ctrl.wipe = 1'b1;
                n_clr     = r_clr + ADDR_W'(1);
                if (r_clr == r_clr_last) begin
                    n_state = tt_pkg::ST_IDLE;
                end
            end
            tt_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = tt_pkg::ST_SLOT;
                end
            end
            tt_pkg::ST_SLOT: begin
                if (r_req == tt_pkg::REQ_CLEAR) begin
                    n_state    = tt_pkg::ST_CLEAR;
                    n_clr      = '0;
                    n_clr_last = clr_last_cfg;
                end else begin
                    ctrl.rd_en = 1'b1;
                    n_state    = tt_pkg::ST_EXEC;
                end
            end
            tt_pkg::ST_CLEAR: begin
                ctrl.wipe = 1'b1;
                n_clr     = r_clr + ADDR_W'(1);
                if (r_clr == r_clr_last) begin
                    n_state = tt_pkg::ST_EXEC;
                end
            end
            tt_pkg::ST_EXEC: begin
                if (out_free) begin
                    ctrl.exec = 1'b1;
                    n_state   = tt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req   <= tt_pkg::t_req'(i_req_type);
            r_key   <= i_hash_key;
            r_score <= i_score_in;
            r_kind  <= i_kind_in;
            r_depth <= i_search_depth;
            r_ply   <= i_ply_in;
            r_move  <= i_move_in;
        end
    end

    tt_slot #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_slot (
        .i_clk     (i_clk),
        .i_load    (accept),
        .i_key_low (i_hash_key[15:0]),
        .i_mask    (r_cfg_mask),
        .o_slot    (slot)
    );

    tt_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .MATE_MARGIN  (MATE_MARGIN),
        .SCORE_BITS   (SCORE_BITS),
        .MOVE_BITS    (MOVE_BITS)
    ) u_table (
        .i_clk          (i_clk),
        .i_ctrl         (ctrl),
        .i_rd_addr      (slot),
        .i_clr_addr     (r_clr),
        .i_score_min    (r_cfg_min),
        .i_score_max    (r_cfg_max),
        .i_req          (r_req),
        .i_hash_key     (r_key),
        .i_score_in     (r_score),
        .i_kind_in      (r_kind),
        .i_search_depth (r_depth),
        .i_ply_in       (r_ply),
        .i_move_in      (r_move),
        .o_kind_out     (res_kind),
        .o_score_out    (res_score),
        .o_move_found   (res_found),
        .o_move_out     (res_move)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.exec) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.exec) begin
            r_kind_out   <= res_kind;
            r_score_out  <= res_score;
            r_move_found <= res_found;
            r_move_out   <= res_move;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind_out   = r_kind_out;
    assign o_score_out  = $signed(r_score_out);
    assign o_move_found = r_move_found;
    assign o_move_out   = r_move_out;

endmodule

`default_nettype wire

// ===== rtl/tt_slot.sv =====
`default_nettype none

module tt_slot #(
    parameter int  TABLE_ENTRIES = tt_pkg::DEF_TABLE_ENTRIES,
    localparam int ADDR_W        = $clog2(TABLE_ENTRIES)
) (
    input  wire logic              i_clk,
    input  wire logic              i_load,
    input  wire logic [15:0]       i_key_low,
    input  wire logic [15:0]       i_mask,
    output logic      [ADDR_W-1:0] o_slot
);

    logic [15:0] masked;

    assign masked = i_key_low & i_mask;

    if (TABLE_ENTRIES > 65535) begin : g_direct
        // Every masked index already lies inside the table.
        logic [15:0] r_masked;

        always_ff @(posedge i_clk) begin
            if (i_load) begin
                r_masked <= masked;
            end
        end

        assign o_slot = ADDR_W'(r_masked);
    end else begin : g_reduce
        // Remainder by the table size: the quotient comes from a multiply by
        // the rounded-up reciprocal, which is exact for 16-bit operands.
        localparam longint unsigned RECIP_L =
            ((64'd1 << 32) + TABLE_ENTRIES - 1) / TABLE_ENTRIES;
        localparam logic [31:0] RECIP   = 32'(RECIP_L);
        localparam logic [15:0] ENTRIES = 16'(TABLE_ENTRIES);

        logic [15:0] r_masked;
        logic [47:0] r_prod;
        logic [15:0] quot;
        logic [31:0] back;
        logic [15:0] rem;
        logic [15:0] rem_fix;

        always_ff @(posedge i_clk) begin
            if (i_load) begin
                r_masked <= masked;
                r_prod   <= 48'(masked) * 48'(RECIP);
            end
        end

        always_comb begin
            quot    = r_prod[47:32];
            back    = 32'(quot) * 32'(ENTRIES);
            rem     = r_masked - back[15:0];
            rem_fix = (rem >= ENTRIES) ? rem - ENTRIES : rem;
        end

        assign o_slot = ADDR_W'(rem_fix);
    end

endmodule

`default_nettype wire

// ===== rtl/tt_table.sv =====
`default_nettype none

module tt_table #(
    parameter int  TABLE_ENTRIES = tt_pkg::DEF_TABLE_ENTRIES,
    parameter int  MATE_MARGIN   = tt_pkg::DEF_MATE_MARGIN,
    parameter int  SCORE_BITS    = tt_pkg::DEF_SCORE_BITS,
    parameter int  MOVE_BITS     = tt_pkg::DEF_MOVE_BITS,
    localparam int ADDR_W        = $clog2(TABLE_ENTRIES)
) (
    input  wire logic               i_clk,
    input  wire tt_pkg::t_tbl_ctrl  i_ctrl,
    input  wire logic [ADDR_W-1:0]  i_rd_addr,
    input  wire logic [ADDR_W-1:0]  i_clr_addr,
    input  wire logic signed [15:0] i_score_min,
    input  wire logic signed [15:0] i_score_max,
    input  wire tt_pkg::t_req       i_req,
    input  wire logic [63:0]        i_hash_key,
    input  wire logic signed [15:0] i_score_in,
    input  wire logic [2:0]         i_kind_in,
    input  wire logic [7:0]         i_search_depth,
    input  wire logic [7:0]         i_ply_in,
    input  wire logic [15:0]        i_move_in,
    output logic      [2:0]         o_kind_out,
    output logic      [15:0]        o_score_out,
    output logic                    o_move_found,
    output logic      [15:0]        o_move_out
);

    localparam int CW = 34;
    localparam logic signed [CW-1:0] SAT_HI =
        CW'((64'sd1 <<< (SCORE_BITS - 1)) - 64'sd1);
    localparam logic signed [CW-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [CW-1:0] MARGIN = CW'(MATE_MARGIN);

    typedef struct packed {
        logic [2:0]            kind;
        logic [63:0]           key;
        logic [SCORE_BITS-1:0] score;
        logic [7:0]            depth;
        logic [MOVE_BITS-1:0]  move;
    } t_entry;

    t_entry              mem [TABLE_ENTRIES];
    t_entry              r_rd;
    logic [ADDR_W-1:0]   r_addr;

    logic signed [CW-1:0] lo_edge;
    logic signed [CW-1:0] hi_edge;
    logic signed [CW-1:0] st_score;
    logic signed [CW-1:0] lk_score;
    logic [MOVE_BITS-1:0] mv;
    logic                 hit;
    logic                 wr_en;
    t_entry               wr_entry;
    logic                 we;
    logic [ADDR_W-1:0]    wa;
    t_entry               wd;

    // Mate scores move away from zero by ply on store and back on lookup,
    // then clip to the stored score range.
    function automatic logic signed [CW-1:0] mate_shift(
        input logic signed [CW-1:0] s,
        input logic signed [CW-1:0] lo,
        input logic signed [CW-1:0] hi,
        input logic [7:0]           ply,
        input logic                 lookup
    );
        logic signed [CW-1:0] p;
        logic signed [CW-1:0] v;
        p = $signed({{(CW-8){1'b0}}, ply});
        v = s;
        if (s < lo) begin
            v = lookup ? s + p : s - p;
        end else if (s > hi) begin
            v = lookup ? s - p : s + p;
        end
        if (v > SAT_HI) begin
            v = SAT_HI;
        end else if (v < SAT_LO) begin
            v = SAT_LO;
        end
        return v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_rd   <= mem[i_rd_addr];
            r_addr <= i_rd_addr;
        end
        if (we) begin
            mem[wa] <= wd;
        end
    end

    always_comb begin
        lo_edge  = CW'(i_score_min) + MARGIN;
        hi_edge  = CW'(i_score_max) - MARGIN;
        st_score = mate_shift(CW'(i_score_in), lo_edge, hi_edge, i_ply_in, 1'b0);
        lk_score = mate_shift(CW'($signed(r_rd.score)), lo_edge, hi_edge, i_ply_in, 1'b1);
        mv       = MOVE_BITS'(i_move_in);
        hit      = (r_rd.kind != tt_pkg::KIND_NONE) && (r_rd.key == i_hash_key);
    end

    always_comb begin
        wr_en        = 1'b0;
        wr_entry     = r_rd;
        o_kind_out   = tt_pkg::KIND_NONE;
        o_score_out  = '0;
        o_move_found = 1'b0;
        o_move_out   = '0;
        case (i_req)
            tt_pkg::REQ_STORE: begin
                // A deeper result for the same position is kept.
                if (!(hit && (r_rd.depth > i_search_depth))) begin
                    wr_en    = 1'b1;
                    wr_entry = '{kind:  i_kind_in,
                                 key:   i_hash_key,
                                 score: SCORE_BITS'(st_score),
                                 depth: i_search_depth,
                                 move:  mv};
                end
            end
            tt_pkg::REQ_SET_MOVE: begin
                wr_en = 1'b1;
                if (hit) begin
                    wr_entry.move = mv;
                end else begin
                    wr_entry = '{kind:  tt_pkg::KIND_PV,
                                 key:   i_hash_key,
                                 score: '0,
                                 depth: 8'd0,
                                 move:  mv};
                end
            end
            tt_pkg::REQ_LOOKUP: begin
                if (hit) begin
                    o_move_found = 1'b1;
                    o_move_out   = 16'(r_rd.move);
                    if ((r_rd.depth >= i_search_depth) && (r_rd.kind != tt_pkg::KIND_PV)) begin
                        o_kind_out  = r_rd.kind;
                        o_score_out = 16'($unsigned(SCORE_BITS'(lk_score)));
                    end
                end
            end
            tt_pkg::REQ_CLEAR: begin
            end
        endcase
    end

    always_comb begin
        we = i_ctrl.wipe || (i_ctrl.exec && wr_en);
        wa = i_ctrl.wipe ? i_clr_addr : r_addr;
        wd = wr_entry;
        if (i_ctrl.wipe) begin
            wd.kind = tt_pkg::KIND_NONE;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tt_checker.sv =====
`default_nettype none

module tt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [2:0]  o_kind_out,
    input wire logic [15:0] o_score_out,
    input wire logic        o_move_found,
    input wire logic [15:0] o_move_out
);

    // A result held back by the receiver keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_kind_out) && $stable(o_score_out) &&
            $stable(o_move_found) && $stable(o_move_out))
        else $error("result changed while stalled");

    // Only one request is worked on at a time.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while busy");

    // Without a key match nothing at all is reported.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_move_found |->
            (o_kind_out == tt_pkg::KIND_NONE) && (o_score_out == 16'd0) &&
            (o_move_out == 16'd0))
        else $error("fields set without a key match");

    a_no_kind_zero_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind_out == tt_pkg::KIND_NONE) |-> o_score_out == 16'd0)
        else $error("score reported without a kind");

    // A PV entry never yields a usable score.
    a_no_pv_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_kind_out != tt_pkg::KIND_PV)
        else $error("PV kind reported by lookup");

endmodule

bind transposition_table tt_checker u_tt_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_transposition_table.sv =====
`timescale 1ns / 100ps

typedef struct packed {
    tt_pkg::t_req       req;
    logic [63:0]        key;
    logic signed [15:0] score;
    logic [2:0]         kind;
    logic [7:0]         depth;
    logic [7:0]         ply;
    logic [15:0]        move;
} t_request;

typedef struct packed {
    logic [2:0]         kind;
    logic signed [15:0] score;
    logic               found;
    logic [15:0]        move;
} t_reply;

class t_scoreboard;
    logic [2:0]         slot_kind  [tt_pkg::DEF_TABLE_ENTRIES];
    logic [63:0]        slot_key   [tt_pkg::DEF_TABLE_ENTRIES];
    logic signed [15:0] slot_score [tt_pkg::DEF_TABLE_ENTRIES];
    logic [7:0]         slot_depth [tt_pkg::DEF_TABLE_ENTRIES];
    logic [15:0]        slot_move  [tt_pkg::DEF_TABLE_ENTRIES];
    logic [15:0]        index_mask;
    logic signed [15:0] score_min;
    logic signed [15:0] score_max;
    t_reply             awaited [$];
    int                 mismatches;

    function new();
        for (int i = 0; i < tt_pkg::DEF_TABLE_ENTRIES; i++) begin
            slot_kind[i]  = tt_pkg::KIND_NONE;
            slot_key[i]   = '0;
            slot_score[i] = '0;
            slot_depth[i] = '0;
            slot_move[i]  = '0;
        end
        index_mask = tt_pkg::RST_INDEX_MASK;
        score_min  = tt_pkg::RST_SCORE_MIN;
        score_max  = tt_pkg::RST_SCORE_MAX;
        mismatches = 0;
    endfunction

    function void set_register(logic [tt_pkg::CFG_IDX_W-1:0] idx,
                               logic [tt_pkg::CFG_W-1:0] value);
        case (idx)
            tt_pkg::CFG_INDEX_MASK: index_mask = value;
            tt_pkg::CFG_SCORE_MIN:  score_min  = value;
            tt_pkg::CFG_SCORE_MAX:  score_max  = value;
            default: ;
        endcase
    endfunction

    function int slot_of(logic [63:0] key);
        return int'(key & 64'(index_mask)) % tt_pkg::DEF_TABLE_ENTRIES;
    endfunction

    function bit holds(int slot, logic [63:0] key);
        return slot_kind[slot] != tt_pkg::KIND_NONE && slot_key[slot] == key;
    endfunction

    // Scores inside a mate band move away from zero by ply on store (dir -1)
    // and back toward zero on lookup (dir +1), saturating to the score range.
    function logic signed [15:0] mate_adjust(logic signed [15:0] s, logic [7:0] ply, int dir);
        longint v;
        longint hi;
        hi = (longint'(1) << (tt_pkg::DEF_SCORE_BITS - 1)) - 1;
        v  = s;
        if (v < longint'(score_min) + tt_pkg::DEF_MATE_MARGIN)
            v = v + dir * longint'(ply);
        else if (v > longint'(score_max) - tt_pkg::DEF_MATE_MARGIN)
            v = v - dir * longint'(ply);
        if (v > hi)
            v = hi;
        else if (v < -hi - 1)
            v = -hi - 1;
        return 16'(v);
    endfunction

    function void store_entry(int slot, logic [63:0] key, logic signed [15:0] score,
                              logic [2:0] kind, logic [7:0] depth, logic [7:0] ply,
                              logic [15:0] move);
        if (holds(slot, key) && slot_depth[slot] > depth)
            return;
        slot_key[slot]   = key;
        slot_score[slot] = mate_adjust(score, ply, -1);
        slot_kind[slot]  = kind;
        slot_depth[slot] = depth;
        slot_move[slot]  = move;
    endfunction

    function void note_request(t_request r);
        t_reply reply;
        int     slot;
        reply = '0;
        slot  = slot_of(r.key);
        case (r.req)
            tt_pkg::REQ_STORE: begin
                store_entry(slot, r.key, r.score, r.kind, r.depth, r.ply, r.move);
            end
            tt_pkg::REQ_SET_MOVE: begin
                if (holds(slot, r.key))
                    slot_move[slot] = r.move;
                else
                    store_entry(slot, r.key, '0, tt_pkg::KIND_PV, '0, '0, r.move);
            end
            tt_pkg::REQ_LOOKUP: begin
                if (holds(slot, r.key)) begin
                    reply.found = 1'b1;
                    reply.move  = slot_move[slot];
                    if (slot_depth[slot] >= r.depth && slot_kind[slot] != tt_pkg::KIND_PV) begin
                        reply.kind  = slot_kind[slot];
                        reply.score = mate_adjust(slot_score[slot], r.ply, 1);
                    end
                end
            end
            default: begin
                for (int j = 0; j <= int'(index_mask) && j < tt_pkg::DEF_TABLE_ENTRIES; j++)
                    slot_kind[j] = tt_pkg::KIND_NONE;
            end
        endcase
        awaited.push_back(reply);
    endfunction

    function void check_result(t_reply got);
        t_reply want;
        if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected result kind %0d score %0d found %0b move %h",
                         $time, got.kind, got.score, got.found, got.move);
            return;
        end
        want = awaited.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: result mismatch, expected kind %0d score %0d found %0b move %h",
                         $time, want.kind, want.score, want.found, want.move);
                $display("%0t: result mismatch, got kind %0d score %0d found %0b move %h",
                         $time, got.kind, got.score, got.found, got.move);
            end
        end
    endfunction
endclass

module tb_transposition_table;

    localparam logic [tt_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX   = 2'd3;
    localparam logic [15:0]                  CLEAR_MASK_LIMIT = 16'd4095;
    localparam int                           LONG_HOLD        = 400;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [tt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tt_pkg::CFG_W-1:0]      cfg_data  = '0;
    logic                          in_valid  = 1'b0;
    logic                          out_stall = 1'b0;
    t_request                      offered   = '0;

    logic                  in_stall;
    logic                  out_valid;
    logic [2:0]            kind_out;
    logic signed [15:0]    score_out;
    logic                  move_found;
    logic [15:0]           move_out;

    t_scoreboard           chk = new();
    logic [63:0]           key_pool [24];
    bit                    offering     = 1'b0;
    int                    in_idle_pct  = 0;
    int                    out_idle_pct = 0;
    int                    hold_orders  = 0;
    int                    hold_served  = 0;

    transposition_table DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_req_type     (offered.req),
        .i_hash_key     (offered.key),
        .i_score_in     (offered.score),
        .i_kind_in      (offered.kind),
        .i_search_depth (offered.depth),
        .i_ply_in       (offered.ply),
        .i_move_in      (offered.move),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_kind_out     (kind_out),
        .o_score_out    (score_out),
        .o_move_found   (move_found),
        .o_move_out     (move_out)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                chk.check_result({kind_out, score_out, move_found, move_out});
            if (in_valid && !in_stall)
                chk.note_request(offered);
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_orders != hold_served) begin
                hold_served = hold_orders;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Keys 8..23 change per phase; keys 16..23 share their slot bits with keys 8..15.
    function automatic void refresh_keys(bit whole);
        for (int i = 0; i < 24; i++) begin
            if (whole || i >= 8) begin
                if (i < 16)
                    key_pool[i] = {$urandom, $urandom};
                else
                    key_pool[i] = {$urandom, 16'($urandom), key_pool[i - 8][15:0]};
            end
        end
    endfunction

    function automatic t_request make_req(tt_pkg::t_req op, logic [63:0] key,
                                          logic signed [15:0] score, logic [2:0] kind,
                                          logic [7:0] depth, logic [7:0] ply,
                                          logic [15:0] move);
        t_request r;
        r.req   = op;
        r.key   = key;
        r.score = score;
        r.kind  = kind;
        r.depth = depth;
        r.ply   = ply;
        r.move  = move;
        return r;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // Scores cluster around the mate band limits of the current setting.
    function automatic logic signed [15:0] pick_score();
        case ($urandom_range(0, 6))
            0: return 16'($urandom);
            1: return 16'sh8000;
            2: return 16'sh7FFF;
            3: return 16'(int'(chk.score_min) + tt_pkg::DEF_MATE_MARGIN
                          + int'($urandom_range(0, 4)) - 2);
            4: return 16'(int'(chk.score_min) + tt_pkg::DEF_MATE_MARGIN
                          - int'($urandom_range(0, 1200)));
            5: return 16'(int'(chk.score_max) - tt_pkg::DEF_MATE_MARGIN
                          + int'($urandom_range(0, 1200)));
            default: return 16'(int'(chk.score_max) - tt_pkg::DEF_MATE_MARGIN
                                + int'($urandom_range(0, 4)) - 2);
        endcase
    endfunction

    function automatic t_request random_request();
        t_request r;
        int       roll;
        roll    = $urandom_range(0, 99);
        r.key   = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                               : key_pool[$urandom_range(0, 23)];
        r.score = pick_score();
        r.kind  = 3'($urandom);
        r.depth = pick_byte();
        r.ply   = pick_byte();
        r.move  = 16'($urandom);
        if (roll < 40)
            r.req = tt_pkg::REQ_STORE;
        else if (roll < 55)
            r.req = tt_pkg::REQ_SET_MOVE;
        else if (roll < 98 || chk.index_mask > CLEAR_MASK_LIMIT)
            r.req = tt_pkg::REQ_LOOKUP;
        else
            r.req = tt_pkg::REQ_CLEAR;
        return r;
    endfunction

    task automatic rest(input int cycles);
        if (offering) begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
        repeat (cycles) @(posedge clk);
    endtask

    task automatic offer(input t_request r);
        offered  <= r;
        in_valid <= 1'b1;
        offering = 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct)
            rest($urandom_range(1, 9));
    endtask

    task automatic send_random(input int count);
        repeat (count) offer(random_request());
    endtask

    // One cycle with valid low lets the last transfer reach the checker first.
    task automatic settle();
        rest(1);
        while (chk.awaited.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [tt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tt_pkg::CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        chk.set_register(idx, value);
        @(posedge clk);
    endtask

    task automatic configure(input logic [15:0] mask, input logic signed [15:0] lo,
                             input logic signed [15:0] hi);
        settle();
        write_reg(tt_pkg::CFG_INDEX_MASK, mask);
        write_reg(tt_pkg::CFG_SCORE_MIN, lo);
        write_reg(tt_pkg::CFG_SCORE_MAX, hi);
        refresh_keys(1'b0);
    endtask

    initial begin
        logic [63:0] k1;
        logic [63:0] k2;
        logic [63:0] k3;
        logic [63:0] k4;
        logic [63:0] k5;
        logic [63:0] k6;
        k1 = 64'h0123_4567_89AB_CDEF;
        k2 = 64'hFFFF_FFFF_FFFF_FFFF;
        k3 = 64'h0;
        k4 = 64'h8000_0000_0000_1234;
        k5 = 64'h5555_AAAA_5555_AAAA;
        k6 = 64'hFEDC_0000_0000_CDEF;
        refresh_keys(1'b1);
        repeat (10) @(posedge clk);
        rst_n       <= 1'b1;
        in_idle_pct = 20;
        out_idle_pct <= 20;

        // Directed part under the reset setting; mate bands lie beyond +-31000.
        offer(make_req(tt_pkg::REQ_LOOKUP, k1, 16'sd0, tt_pkg::KIND_NONE, 8'd0, 8'd0, 16'h0000));
        offer(make_req(tt_pkg::REQ_STORE, k1, 16'sd100, 3'd2, 8'd10, 8'd5, 16'h1234));
        offer(make_req(tt_pkg::REQ_LOOKUP, k1, 16'sd0, tt_pkg::KIND_NONE, 8'd10, 8'd5, 16'h0000));
        offer(make_req(tt_pkg::REQ_LOOKUP, k1, 16'sd0, tt_pkg::KIND_NONE, 8'd11, 8'd5, 16'h0000));
        offer(make_req(tt_pkg::REQ_STORE, k1, 16'sd7, 3'd3, 8'd5, 8'd0, 16'h4321));
        offer(make_req(tt_pkg::REQ_LOOKUP, k1, 16'sd0, tt_pkg::KIND_NONE, 8'd0, 8'd0, 16'h0000));
        offer(make_req(tt_pkg::REQ_STORE, k1, -16'sd31500, 3'd3, 8'd200, 8'd255, 16'h0000));
        offer(make_req(tt_pkg::REQ_LOOKUP, k1, 16'sd0, tt_pkg::KIND_NONE, 8'd200, 8'd0, 16'h0000));
        offer(make_req(tt_pkg::REQ_LOOKUP, k1, 16'sd0, tt_pkg::KIND_NONE, 8'd200, 8'd255,
                       16'h0000));
        offer(make_req(tt_pkg::REQ_STORE, k2, 16'sh7FFF, 3'd7, 8'd255, 8'd255, 16'hFFFF));
        offer(make_req(tt_pkg::REQ_LOOKUP, k2, 16'sd0, tt_pkg::KIND_NONE, 8'd255, 8'd255,
                       16'h0000));
        offer(make_req(tt_pkg::REQ_STORE, k3, 16'sh8000, 3'd4, 8'd0, 8'd255, 16'h8000));
        offer(make_req(tt_pkg::REQ_LOOKUP, k3, 16'sd0, tt_pkg::KIND_NONE, 8'd0, 8'd255, 16'h0000));
        offer(make_req(tt_pkg::REQ_SET_MOVE, k1, 16'sd0, tt_pkg::KIND_NONE, 8'd0, 8'd0, 16'hABCD));
        offer(make_req(tt_pkg::REQ_SET_MOVE, k4, 16'sd0, tt_pkg::KIND_NONE, 8'd0, 8'd0, 16'h0F0F));
        offer(make_req(tt_pkg::REQ_LOOKUP, k4, 16'sd0, tt_pkg::KIND_NONE, 8'd0, 8'd0, 16'h0000));
        // A store of kind none leaves the entry empty.
        offer(make_req(tt_pkg::REQ_STORE, k5, 16'sd5, tt_pkg::KIND_NONE, 8'd3, 8'd0, 16'h5555));
        offer(make_req(tt_pkg::REQ_LOOKUP, k5, 16'sd0, tt_pkg::KIND_NONE, 8'd0, 8'd0, 16'h0000));
        // Same slot, other key: replaced regardless of depth.
        offer(make_req(tt_pkg::REQ_STORE, k6, -16'sd5, 3'd6, 8'd1, 8'd0, 16'h0001));
        offer(make_req(tt_pkg::REQ_LOOKUP, k1, 16'sd0, tt_pkg::KIND_NONE, 8'd0, 8'd0, 16'h0000));
        offer(make_req(tt_pkg::REQ_LOOKUP, k6, 16'sd0, tt_pkg::KIND_NONE, 8'd2, 8'd0, 16'h0000));
        offer(make_req(tt_pkg::REQ_CLEAR, k2, 16'sd0, tt_pkg::KIND_NONE, 8'd0, 8'd0, 16'h0000));
        offer(make_req(tt_pkg::REQ_LOOKUP, k2, 16'sd0, tt_pkg::KIND_NONE, 8'd0, 8'd0, 16'h0000));
        offer(make_req(tt_pkg::REQ_STORE, k3, -16'sd31000, 3'd2, 8'd9, 8'd50, 16'h00FF));
        offer(make_req(tt_pkg::REQ_LOOKUP, k3, 16'sd0, tt_pkg::KIND_NONE, 8'd9, 8'd50, 16'h0000));

        configure(16'h0001, 16'sh8000, 16'sh7FFF);
        in_idle_pct = 25;
        out_idle_pct <= 25;
        send_random(120);
        settle();
        send_random(130);

        // The long hold-off fills the block while the sender keeps offering.
        configure(16'h00FF, -16'sd100, 16'sd100);
        in_idle_pct = 0;
        out_idle_pct <= 0;
        send_random(100);
        hold_orders <= hold_orders + 1;
        send_random(120);
        settle();
        in_idle_pct = 30;
        out_idle_pct <= 30;
        send_random(80);

        configure(16'h000F, 16'sh7FFF, 16'sh8000);
        write_reg(CFG_UNUSED_IDX, 16'($urandom));
        in_idle_pct = 40;
        out_idle_pct <= 10;
        send_random(250);

        configure(16'hFFFF, -16'sd32000, 16'sd32000);
        in_idle_pct = 10;
        out_idle_pct <= 40;
        send_random(250);

        configure(CLEAR_MASK_LIMIT, 16'sh8000, 16'sh7FFF);
        in_idle_pct = 20;
        out_idle_pct <= 20;
        send_random(200);

        configure(16'h003F, -16'sd30000, 16'sd30000);
        in_idle_pct = 0;
        out_idle_pct <= 0;
        send_random(200);

        settle();
        repeat (20) @(posedge clk);
        if (chk.mismatches == 0 && chk.awaited.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tt_pkg.sv
rtl/tt_slot.sv
rtl/tt_table.sv
rtl/transposition_table.sv
rtl/tt_checker.sv
tb/sv/tb_transposition_table.sv
